>>> sv/sssd_pkg.sv
// Package for the seven-segment stopwatch shift driver.
// Holds the result record type and the digit-to-segment encoding.
// No dependencies.
`default_nettype none

package sssd_pkg;

  typedef struct packed {
    logic serial_data;
    logic shift_pulse;
    logic latch_pulse;
    logic running;
  } res_t;

  localparam logic [6:0] MaxValue = 7'd99;

  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hBB;
      4'd1:    seg = 8'h0A;
      4'd2:    seg = 8'h73;
      4'd3:    seg = 8'h5B;
      4'd4:    seg = 8'hCA;
      4'd5:    seg = 8'hD9;
      4'd6:    seg = 8'hFD;
      4'd7:    seg = 8'h0B;
      4'd8:    seg = 8'hFB;
      4'd9:    seg = 8'hDF;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Valid for values up to 99: tens by reciprocal multiply, ones by subtraction.
  function automatic logic [15:0] frame_encode(input logic [6:0] value);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    prod     = 15'({8'd0, value} * 15'd205);
    tens     = prod[14:11];
    tens_x10 = 7'({3'd0, tens} * 7'd10);
    ones     = 4'(value - tens_x10);
    return {seg_encode(tens), seg_encode(ones)};
  endfunction

endpackage

`default_nettype wire

>>> sv/seven_segment_stopwatch_shift_driver_core.sv
// Seven-segment stopwatch shift driver, top level.
// A request's result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one request per cycle while the skid entry is free; a two-entry output stage
// keeps accepting while one result waits to be taken.
// Reset: asynchronous active low; period returns to 1000, all state to idle.
// Depends on sssd_pkg.
`default_nettype none

module seven_segment_stopwatch_shift_driver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [6:0]  entry_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             serial_data_o,
  output logic             shift_pulse_o,
  output logic             latch_pulse_o,
  output logic             running_o
);
  import sssd_pkg::*;

  localparam logic [1:0] PhaseWait  = 2'd0;
  localparam logic [1:0] PhaseShift = 2'd1;
  localparam logic [1:0] PhaseLatch = 2'd2;

  logic [15:0] period_q;
  logic [15:0] tick_q, tick_d;
  logic [6:0]  second_q, second_d;
  logic        started_q, started_d;
  logic        ovr_pend_q, ovr_pend_d;
  logic [6:0]  ovr_held_q, ovr_held_d;
  logic [15:0] frame_q, frame_d;
  logic [3:0]  bitpos_q, bitpos_d;
  logic [1:0]  phase_q, phase_d;

  logic        out_valid_q, skid_valid_q;
  res_t        out_q, skid_q, res_d;
  logic        accept, out_take;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;

  always_comb begin
    logic [16:0] tick_next;
    logic [6:0]  shown;
    tick_d     = tick_q;
    second_d   = second_q;
    started_d  = started_q;
    ovr_pend_d = ovr_pend_q;
    ovr_held_d = ovr_held_q;
    frame_d    = frame_q;
    bitpos_d   = bitpos_q;
    phase_d    = phase_q;
    res_d      = '0;
    tick_next  = {1'b0, tick_q} + 17'd1;
    shown      = ovr_pend_q ? ovr_held_q : second_q;
    if (cmd_i) begin
      if (entry_value_i <= MaxValue) begin
        if (!started_q) begin
          second_d  = entry_value_i;
          started_d = 1'b1;
          tick_d    = period_q - 16'd1;
        end else begin
          ovr_held_d = entry_value_i;
          ovr_pend_d = 1'b1;
        end
      end
    end else begin
      if (tick_next >= {1'b0, period_q}) begin
        tick_d = '0;
        if (started_q) begin
          ovr_pend_d = 1'b0;
          second_d   = (second_q == MaxValue) ? 7'd0 : second_q + 7'd1;
          frame_d    = frame_encode(shown);
          bitpos_d   = 4'd15;
          phase_d    = PhaseShift;
        end
      end else begin
        tick_d = tick_next[15:0];
      end
      case (phase_d)
        PhaseShift: begin
          res_d.serial_data = frame_d[bitpos_d];
          res_d.shift_pulse = 1'b1;
          if (bitpos_d == 4'd0) begin
            phase_d  = PhaseLatch;
            bitpos_d = 4'd15;
          end else begin
            bitpos_d = bitpos_d - 4'd1;
          end
        end
        PhaseLatch: begin
          res_d.latch_pulse = 1'b1;
          phase_d = PhaseWait;
        end
        default: begin
          phase_d = PhaseWait;
        end
      endcase
    end
    res_d.running = started_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= 16'd1000;
      tick_q     <= '0;
      second_q   <= '0;
      started_q  <= 1'b0;
      ovr_pend_q <= 1'b0;
      ovr_held_q <= '0;
      frame_q    <= '0;
      bitpos_q   <= 4'd15;
      phase_q    <= PhaseWait;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (accept) begin
        tick_q     <= tick_d;
        second_q   <= second_d;
        started_q  <= started_d;
        ovr_pend_q <= ovr_pend_d;
        ovr_held_q <= ovr_held_d;
        frame_q    <= frame_d;
        bitpos_q   <= bitpos_d;
        phase_q    <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
        end
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign serial_data_o = out_q.serial_data;
  assign shift_pulse_o = out_q.shift_pulse;
  assign latch_pulse_o = out_q.latch_pulse;
  assign running_o     = out_q.running;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_started_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("running flag dropped");

  a_bitpos_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bitpos_q != 4'd15) |-> (phase_q == PhaseShift))
    else $error("bit position moved outside the shift phase");

  a_pulse_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.shift_pulse && out_q.latch_pulse))
    else $error("shift and latch pulses issued together");

endmodule

`default_nettype wire
